// File: rtl/core/xfp_pkg.sv
// Shared types and constants for the frame parser.
`timescale 1ns / 1ps
`default_nettype none
package xfp_pkg;

  // Frame size limit; frames that reach MAX_FRAME_BYTES - 1 bytes are dropped.
  localparam int MAX_FRAME_BYTES = 256;

  // Position counter width: wide enough for the limit, never below a byte.
  localparam int POS_W = ($clog2(MAX_FRAME_BYTES) > 8) ? $clog2(MAX_FRAME_BYTES) : 8;
  // Compare width: holds position + 1 and 4 + payload length.
  localparam int CMP_W = POS_W + 2;

  localparam logic [7:0] PREAMBLE    = 8'hFA;
  localparam logic [7:0] BUS_ID      = 8'hFF;
  localparam logic [7:0] LEN_EXT     = 8'hFF;
  localparam logic [7:0] HDR_BYTES   = 8'd4;

  // Parser phases
  localparam logic [2:0] PH_PRE  = 3'd0;
  localparam logic [2:0] PH_BUS  = 3'd1;
  localparam logic [2:0] PH_MID  = 3'd2;
  localparam logic [2:0] PH_LEN  = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;
  localparam logic [2:0] PH_CHK  = 3'd5;

  // Event codes on the last byte of a frame
  localparam logic [2:0] EV_NONE = 3'd0;
  localparam logic [2:0] EV_GOOD = 3'd1;
  localparam logic [2:0] EV_CSUM = 3'd2;
  localparam logic [2:0] EV_SYNC = 3'd3;
  localparam logic [2:0] EV_OVER = 3'd4;

  typedef struct packed {
    logic [7:0] rx_byte;
  } xfp_in_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic        in_frame;
    logic [7:0]  byte_index;
    logic [7:0]  byte_out;
    logic [7:0]  frame_length;
    logic [7:0]  message_id;
    logic [31:0] sync_error_count;
    logic [31:0] checksum_error_count;
    logic [31:0] oversized_count;
    logic [31:0] frame_count;
    logic [31:0] byte_count;
  } xfp_out_t;

endpackage
`default_nettype wire

// File: rtl/core/xfp_if.sv
// Valid/ready channel interfaces for the parser input and result streams.
`timescale 1ns / 1ps
`default_nettype none
interface xfp_in_if import xfp_pkg::*; ();
  logic    valid;
  logic    ready;
  xfp_in_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface xfp_out_if import xfp_pkg::*; ();
  logic     valid;
  logic     ready;
  xfp_out_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: rtl/core/xbus_frame_parser_unit.sv
// Byte-stream frame parser: finds preamble/bus-id framed messages, checks sums.
`timescale 1ns / 1ps
`default_nettype none
// Usage
//   in_ch  : one received byte per transfer (valid/ready).
//   out_ch : one result per input byte: event code, in-frame flag, index in
//            frame, the byte itself, frame length on completion, message id
//            and five wrapping 32-bit counters as they stand after the byte.
//   Latency: result valid the cycle after the input transfer.
//   Throughput: one byte per cycle while not stalled. The parser state
//   updates in a single pass of narrow logic per byte; the result register
//   is the only stage. Stall: in_ch.ready is high whenever the result
//   register is empty or is being drained this cycle, so a stalled receiver
//   holds the result and blocks input only while the register stays full.
//   Reset (rst_n low, synchronous): parser waits for a preamble, all
//   counters clear, result register empties.
//   Event codes: good frame, checksum bad, sync error, oversized; a consumer
//   keeps the buffered bytes only when the last byte reports good.
module xbus_frame_parser_unit
  import xfp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  xfp_in_if.sink     in_ch,
  xfp_out_if.source  out_ch
);

  logic [2:0]       phase_r, phase_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       len_r, len_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [7:0]       mid_r, mid_nxt;
  logic [31:0]      sync_cnt_r, sync_cnt_nxt;
  logic [31:0]      csum_cnt_r, csum_cnt_nxt;
  logic [31:0]      over_cnt_r, over_cnt_nxt;
  logic [31:0]      good_cnt_r, good_cnt_nxt;
  logic [31:0]      byte_cnt_r, byte_cnt_nxt;

  logic             out_valid_r;
  xfp_out_t         res_r, res_nxt;

  logic             in_xfer;
  logic [7:0]       b;
  logic [7:0]       sum_add;
  logic [CMP_W-1:0] pos_inc;
  logic [CMP_W-1:0] data_end;
  logic [2:0]       ev;
  logic             inf;
  logic [POS_W-1:0] idx;
  logic [POS_W-1:0] flen;

  assign in_ch.ready    = !out_valid_r || out_ch.ready;
  assign in_xfer        = in_ch.valid && in_ch.ready;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = res_r;

  assign b        = in_ch.payload.rx_byte;
  assign sum_add  = sum_r + b;
  assign pos_inc  = CMP_W'(pos_r) + CMP_W'(1);
  assign data_end = CMP_W'(HDR_BYTES) + CMP_W'(len_r);

  always_comb begin
    phase_nxt    = phase_r;
    pos_nxt      = pos_r;
    len_nxt      = len_r;
    sum_nxt      = sum_r;
    mid_nxt      = mid_r;
    sync_cnt_nxt = sync_cnt_r;
    csum_cnt_nxt = csum_cnt_r;
    over_cnt_nxt = over_cnt_r;
    good_cnt_nxt = good_cnt_r;
    byte_cnt_nxt = byte_cnt_r + 32'd1;
    ev           = EV_NONE;
    inf          = 1'b1;
    idx          = '0;
    flen         = '0;

    unique case (phase_r)
      PH_BUS: begin
        if (b == BUS_ID) begin
          idx       = POS_W'(1);
          sum_nxt   = sum_add;
          pos_nxt   = POS_W'(2);
          phase_nxt = PH_MID;
        end else begin
          sync_cnt_nxt = sync_cnt_r + 32'd1;
          ev           = EV_SYNC;
          if (b == PREAMBLE) begin
            // restart on a fresh preamble
            phase_nxt = PH_BUS;
            pos_nxt   = POS_W'(1);
            sum_nxt   = '0;
            mid_nxt   = '0;
            len_nxt   = '0;
          end else begin
            inf       = 1'b0;
            phase_nxt = PH_PRE;
            pos_nxt   = '0;
            len_nxt   = '0;
          end
        end
      end
      PH_MID: begin
        idx       = POS_W'(2);
        sum_nxt   = sum_add;
        mid_nxt   = b;
        pos_nxt   = POS_W'(3);
        phase_nxt = PH_LEN;
      end
      PH_LEN: begin
        idx     = POS_W'(3);
        sum_nxt = sum_add;
        len_nxt = b;
        pos_nxt = POS_W'(4);
        if (b == LEN_EXT) begin
          // extended length not supported
          over_cnt_nxt = over_cnt_r + 32'd1;
          ev           = EV_OVER;
          phase_nxt    = PH_PRE;
          pos_nxt      = '0;
          len_nxt      = '0;
        end else if (b == 8'd0) begin
          phase_nxt = PH_CHK;
        end else begin
          phase_nxt = PH_DATA;
        end
      end
      PH_DATA: begin
        idx     = pos_r;
        sum_nxt = sum_add;
        pos_nxt = pos_inc[POS_W-1:0];
        if (pos_inc == data_end) begin
          phase_nxt = PH_CHK;
        end
        if (pos_inc >= CMP_W'(MAX_FRAME_BYTES - 1)) begin
          over_cnt_nxt = over_cnt_r + 32'd1;
          ev           = EV_OVER;
          phase_nxt    = PH_PRE;
          pos_nxt      = '0;
          len_nxt      = '0;
        end
      end
      PH_CHK: begin
        idx     = pos_r;
        sum_nxt = sum_add;
        flen    = pos_inc[POS_W-1:0];
        if (sum_add == 8'd0) begin
          good_cnt_nxt = good_cnt_r + 32'd1;
          ev           = EV_GOOD;
        end else begin
          csum_cnt_nxt = csum_cnt_r + 32'd1;
          ev           = EV_CSUM;
        end
        phase_nxt = PH_PRE;
        pos_nxt   = '0;
        len_nxt   = '0;
      end
      default: begin
        // waiting for preamble; spare codes behave the same
        if (b == PREAMBLE) begin
          phase_nxt = PH_BUS;
          pos_nxt   = POS_W'(1);
          sum_nxt   = '0;
          mid_nxt   = '0;
          len_nxt   = '0;
        end else begin
          inf          = 1'b0;
          sync_cnt_nxt = sync_cnt_r + 32'd1;
          ev           = EV_SYNC;
        end
      end
    endcase

    res_nxt.event_res            = ev;
    res_nxt.in_frame             = inf;
    res_nxt.byte_index           = idx[7:0];
    res_nxt.byte_out             = b;
    res_nxt.frame_length         = flen[7:0];
    res_nxt.message_id           = inf ? mid_nxt : 8'd0;
    res_nxt.sync_error_count     = sync_cnt_nxt;
    res_nxt.checksum_error_count = csum_cnt_nxt;
    res_nxt.oversized_count      = over_cnt_nxt;
    res_nxt.frame_count          = good_cnt_nxt;
    res_nxt.byte_count           = byte_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_PRE;
      pos_r       <= '0;
      len_r       <= '0;
      sum_r       <= '0;
      mid_r       <= '0;
      sync_cnt_r  <= '0;
      csum_cnt_r  <= '0;
      over_cnt_r  <= '0;
      good_cnt_r  <= '0;
      byte_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        phase_r    <= phase_nxt;
        pos_r      <= pos_nxt;
        len_r      <= len_nxt;
        sum_r      <= sum_nxt;
        mid_r      <= mid_nxt;
        sync_cnt_r <= sync_cnt_nxt;
        csum_cnt_r <= csum_cnt_nxt;
        over_cnt_r <= over_cnt_nxt;
        good_cnt_r <= good_cnt_nxt;
        byte_cnt_r <= byte_cnt_nxt;
      end
      if (in_xfer) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload: no reset needed
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res_r <= res_nxt;
    end
  end

`ifndef SYNTHESIS
  a_byte_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> byte_cnt_r == $past(byte_cnt_r) + 32'd1)
    else $error("byte counter did not advance by one per transfer");

  a_out_of_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !res_r.in_frame |->
      res_r.byte_index == 8'd0 && res_r.message_id == 8'd0 &&
      res_r.event_res == EV_SYNC)
    else $error("out-of-frame byte carries frame fields");

  a_flen_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.frame_length != 8'd0 |->
      res_r.event_res == EV_GOOD || res_r.event_res == EV_CSUM)
    else $error("frame length reported without frame completion");

  a_good_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && res_nxt.event_res == EV_GOOD |=> good_cnt_r == $past(good_cnt_r) + 32'd1)
    else $error("good frame not counted");

  a_idle_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && (res_nxt.event_res == EV_GOOD || res_nxt.event_res == EV_CSUM ||
                res_nxt.event_res == EV_OVER) |=> phase_r == PH_PRE && pos_r == '0)
    else $error("parser not back to preamble search after frame end");
`endif

endmodule
`default_nettype wire

// File: verif/tb.sv
// Self-checking bench for the frame parser: directed, size-limit, random and back-pressure tests.
`timescale 1ns / 1ps

module tb;
  import xfp_pkg::*;

  // Run-length guard: about 1500 bytes plus the long receiver hold, with a wide margin.
  localparam int CYCLE_LIMIT = 400000;
  // Result register is the only stage, so a few cycles cover the drain.
  localparam int DRAIN_CYCLES = 8;

  logic clk;
  logic rst_n;

  xfp_in_if  in_ch ();
  xfp_out_if out_ch ();

  xbus_frame_parser_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Stimulus shaping knobs, percentages per cycle
  int gap_pct;      // chance the sender sits idle this cycle
  int stall_pct;    // chance the receiver drops ready this cycle
  int hold_left;    // forced receiver hold-off, counted down in cycles

  int bytes_sent;
  int mismatches;
  int cycle_cnt;

  // Results predicted at input transfer, oldest first
  xfp_out_t pending_results[$];

  // ---------------------------------------------------------------------------
  // Parser shadow state, advanced once per accepted byte
  // ---------------------------------------------------------------------------
  logic [2:0]  sh_phase;
  int unsigned sh_pos;      // kept wide: the end-of-data compare against 4 + length needs > 8 bits
  logic [7:0]  sh_plen;
  logic [7:0]  sh_sum;
  logic [7:0]  sh_mid;
  logic [31:0] sh_sync;
  logic [31:0] sh_csum;
  logic [31:0] sh_over;
  logic [31:0] sh_good;
  logic [31:0] sh_bytes;

  // Abandon the candidate and hunt for a preamble again
  function automatic void shadow_drop();
    sh_phase = PH_PRE;
    sh_pos   = 0;
    sh_plen  = '0;
  endfunction

  // Preamble seen: sum and id restart, bus id expected next
  function automatic void shadow_open();
    sh_phase = PH_BUS;
    sh_pos   = 1;
    sh_sum   = '0;
    sh_mid   = '0;
    sh_plen  = '0;
  endfunction

  // Expected result for one received byte; updates the shadow state
  function automatic xfp_out_t parse_byte(input logic [7:0] b);
    xfp_out_t    r;
    logic [2:0]  ev;
    logic        inf;
    int unsigned idx;
    int unsigned flen;
    ev   = EV_NONE;
    inf  = 1'b1;
    idx  = 0;
    flen = 0;
    sh_bytes++;
    case (sh_phase)
      PH_BUS: begin
        if (b == BUS_ID) begin
          idx      = 1;
          sh_sum   = sh_sum + b;
          sh_pos   = 2;
          sh_phase = PH_MID;
        end else begin
          // wrong bus id; a fresh preamble here restarts the frame
          sh_sync++;
          ev = EV_SYNC;
          if (b == PREAMBLE) begin
            shadow_open();
          end else begin
            inf = 1'b0;
            shadow_drop();
          end
        end
      end
      PH_MID: begin
        idx      = 2;
        sh_sum   = sh_sum + b;
        sh_mid   = b;
        sh_pos   = 3;
        sh_phase = PH_LEN;
      end
      PH_LEN: begin
        idx     = 3;
        sh_sum  = sh_sum + b;
        sh_plen = b;
        sh_pos  = 4;
        if (b == LEN_EXT) begin
          // extended length is not supported: dropped as oversized
          sh_over++;
          ev = EV_OVER;
          shadow_drop();
        end else if (b == 8'd0) begin
          sh_phase = PH_CHK;
        end else begin
          sh_phase = PH_DATA;
        end
      end
      PH_DATA: begin
        idx    = sh_pos;
        sh_sum = sh_sum + b;
        sh_pos++;
        if (sh_pos == 4 + sh_plen) sh_phase = PH_CHK;
        // size limit wins even on the last data byte
        if (sh_pos >= MAX_FRAME_BYTES - 1) begin
          sh_over++;
          ev = EV_OVER;
          shadow_drop();
        end
      end
      PH_CHK: begin
        idx    = sh_pos;
        sh_sum = sh_sum + b;
        sh_pos++;
        flen   = sh_pos;
        if (sh_sum == 8'd0) begin
          sh_good++;
          ev = EV_GOOD;
        end else begin
          sh_csum++;
          ev = EV_CSUM;
        end
        shadow_drop();
      end
      default: begin
        // waiting for a preamble; unused phase codes behave the same
        if (b == PREAMBLE) begin
          shadow_open();
        end else begin
          inf = 1'b0;
          sh_sync++;
          ev = EV_SYNC;
        end
      end
    endcase
    r.event_res            = ev;
    r.in_frame             = inf;
    r.byte_index           = idx[7:0];
    r.byte_out             = b;
    r.frame_length         = flen[7:0];
    r.message_id           = inf ? sh_mid : 8'd0;
    r.sync_error_count     = sh_sync;
    r.checksum_error_count = sh_csum;
    r.oversized_count      = sh_over;
    r.frame_count          = sh_good;
    r.byte_count           = sh_bytes;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, cycle guard
  // ---------------------------------------------------------------------------
  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("** xbus_frame_parser_unit: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: ready changes on the falling edge. A forced hold-off takes
  // precedence over the random stall.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: each output transfer against the oldest prediction
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    xfp_out_t want;
    xfp_out_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.payload;
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing predicted (byte 0x%0h)", got.byte_out);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("event_res",            want.event_res,            got.event_res);
        check_field("in_frame",             want.in_frame,             got.in_frame);
        check_field("byte_index",           want.byte_index,           got.byte_index);
        check_field("byte_out",             want.byte_out,             got.byte_out);
        check_field("frame_length",         want.frame_length,         got.frame_length);
        check_field("message_id",           want.message_id,           got.message_id);
        check_field("sync_error_count",     want.sync_error_count,     got.sync_error_count);
        check_field("checksum_error_count", want.checksum_error_count,
                    got.checksum_error_count);
        check_field("oversized_count",      want.oversized_count,      got.oversized_count);
        check_field("frame_count",          want.frame_count,          got.frame_count);
        check_field("byte_count",           want.byte_count,           got.byte_count);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender. Entered and left on a falling edge. Valid stays high between
  // back-to-back bytes and is only lowered in a step of its own.
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.payload.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(parse_byte(b));
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic idle_input();
    in_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Whole frame with random data; checksum right or deliberately off.
  // A non-zero cut sends only that many leading bytes.
  task automatic send_frame(input logic [7:0] mid, input int len, input bit sum_ok,
                            input int cut);
    logic [7:0] frame_q[$];
    logic [7:0] sum;
    int         n;
    frame_q = {PREAMBLE, BUS_ID, mid, 8'(len)};
    sum     = BUS_ID + mid + 8'(len);
    for (int i = 0; i < len; i++) begin
      frame_q.push_back(8'($urandom));
      sum = sum + frame_q[$];
    end
    sum = -sum;
    if (!sum_ok) sum = sum + 8'($urandom_range(1, 255));
    frame_q.push_back(sum);
    n = (cut > 0 && cut < frame_q.size()) ? cut : frame_q.size();
    for (int i = 0; i < n; i++) send_byte(frame_q[i]);
  endtask

  // Hold until every predicted result has been seen
  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Extremes and every event: stray bytes, bad bus id, restart on a second
  // preamble, empty frame, extended length, checksum fail, good frame.
  task automatic test_directed_cases();
    gap_pct   = 0;
    stall_pct = 0;
    send_byte(8'h00);                 // stray byte, sync error
    send_byte(8'hFF);
    send_byte(PREAMBLE);
    send_byte(8'h12);                 // wrong bus id, out of frame
    send_byte(PREAMBLE);
    send_byte(PREAMBLE);              // wrong bus id but a preamble: restart
    send_byte(BUS_ID);
    send_byte(8'h00);                 // message id 0
    send_byte(8'h00);                 // empty payload
    send_byte(8'h01);                 // 0xFF + 0 + 0 + 1 == 0
    send_frame(8'hFF, 255, 1'b1, 4);  // extended length, dropped on the length byte
    send_frame(8'h80, 2, 1'b0, 0);    // checksum bad
    send_frame(8'h7F, 1, 1'b1, 0);    // good
    idle_input();
    wait_drained();
  endtask

  // Longest frame that still fits, then one that reaches the limit on its
  // last data byte; the trailing checksum then arrives as a stray byte.
  task automatic test_size_limit();
    gap_pct   = 20;
    stall_pct = 20;
    send_frame(8'h5A, MAX_FRAME_BYTES - 6, 1'b1, 0);
    send_frame(8'hA5, MAX_FRAME_BYTES - 5, 1'b1, 0);
    idle_input();
    wait_drained();
  endtask

  // Mostly well-formed frames with random content, the rest noise, cut-off
  // frames, extended lengths and bad bus ids.
  task automatic test_random_traffic(input int gap, input int stall, input int budget);
    int first;
    int kind;
    int len;
    first     = bytes_sent;
    gap_pct   = gap;
    stall_pct = stall;
    while (bytes_sent - first < budget) begin
      kind = $urandom_range(99);
      // lengths: mostly short, now and then near the limit
      if ($urandom_range(59) == 0) len = $urandom_range(MAX_FRAME_BYTES - 11, 254);
      else if ($urandom_range(9) == 0) len = $urandom_range(17, 80);
      else len = $urandom_range(0, 16);
      if (kind < 70) begin
        send_frame(8'($urandom), len, $urandom_range(3) != 0, 0);
      end else if (kind < 80) begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
      end else if (kind < 90) begin
        send_frame(8'($urandom), len, 1'b1, $urandom_range(1, len + 4));
      end else if (kind < 95) begin
        send_frame(8'($urandom), 255, 1'b1, 4);
      end else begin
        send_byte(PREAMBLE);
        send_byte(($urandom_range(1) != 0) ? PREAMBLE : 8'($urandom));
      end
    end
    idle_input();
    wait_drained();
  endtask

  // Receiver holds off for a long stretch while bytes keep coming, so the
  // result register fills and input ready must drop.
  task automatic test_output_backpressure();
    gap_pct   = 0;
    stall_pct = 0;
    @(posedge clk);
    hold_left = 80;
    @(negedge clk);
    repeat (4) send_frame(8'($urandom), $urandom_range(0, 6), 1'b1, 0);
    idle_input();
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.payload = '0;
    out_ch.ready  = 1'b0;
    gap_pct       = 0;
    stall_pct     = 0;
    hold_left     = 0;
    bytes_sent    = 0;
    mismatches    = 0;
    cycle_cnt     = 0;
    sh_sync       = '0;
    sh_csum       = '0;
    sh_over       = '0;
    sh_good       = '0;
    sh_bytes      = '0;
    shadow_drop();
    sh_sum        = '0;
    sh_mid        = '0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_size_limit();
    test_random_traffic(0, 0, 230);     // no idling
    test_random_traffic(75, 0, 220);    // sender mostly idle
    test_random_traffic(0, 75, 220);    // receiver mostly stalled
    test_random_traffic(16, 16, 220);   // light idling on both sides
    test_output_backpressure();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("** xbus_frame_parser_unit: PASSED **");
    end else begin
      $display("** xbus_frame_parser_unit: FAILED **");
    end
    $finish;
  end

endmodule
